// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/olidl_pkg.sv =====
`timescale 1ns / 1ps

package olidl_pkg;

	// list geometry
	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int WORD_W   = 32;
	localparam int POS_W    = 5;
	localparam int KIND_W   = 2;
	// common width for position and count compares, with headroom for count + 1
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// input word layout
	localparam int IN_BITS     = POS_W + WORD_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int IN_POS_LSB  = 0;
	localparam int IN_VAL_LSB  = POS_W;

	// output word layout
	localparam int OK_BIT      = 0;
	localparam int FOUND_LSB   = 1;
	localparam int REMOVED_LSB = FOUND_LSB + POS_W;
	localparam int COUNT_LSB   = REMOVED_LSB + WORD_W;
	localparam int OUT_BITS    = COUNT_LSB + POS_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// requested operation
	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_LOCATE = 2'd2
	} kind_t;

	// what every cell does this cycle
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} cell_op_t;

	// broadcast to the whole chain
	typedef struct packed {
		cell_op_t            op;
		logic [CMP_W-1:0]    pos;
		logic [CMP_W-1:0]    count;
		logic [WORD_W-1:0]   value;
	} cell_cmd_t;

	// low five bits of a count or place, as carried on the result word
	function automatic logic [POS_W-1:0] fit_pos(input logic [CMP_W-1:0] v);
		return v[POS_W-1:0];
	endfunction

endpackage

// ===== rtl/core/olidl_cell.sv =====
`timescale 1ns / 1ps

module olidl_cell import olidl_pkg::*; (
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [CNT_W-1:0]  slot,        // 1-based place of this cell
	input  logic [WORD_W-1:0] left_entry,  // entry of the cell one place lower
	input  logic [WORD_W-1:0] right_entry, // entry of the cell one place higher
	output logic [WORD_W-1:0] entry,
	output logic              hit,
	output logic [WORD_W-1:0] tap
);

	logic [WORD_W-1:0] entry_q;
	logic [WORD_W-1:0] entry_nxt;
	logic [CMP_W-1:0]  slot_x;

	assign slot_x = CMP_W'(slot);

	// load, shift up or shift down
	always_comb begin
		entry_nxt = entry_q;
		unique case (cmd.op)
			OP_HOLD: begin
				entry_nxt = entry_q;
			end
			OP_INSERT: begin
				if (slot_x == cmd.pos) begin
					entry_nxt = cmd.value;
				end else if (slot_x > cmd.pos) begin
					entry_nxt = left_entry;
				end
			end
			OP_DELETE: begin
				if (slot_x >= cmd.pos) begin
					entry_nxt = right_entry;
				end
			end
			default: begin
				entry_nxt = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

	// match against the search word, only inside the filled part
	assign hit   = (slot_x <= cmd.count) && (entry_q == cmd.value);
	// own entry when this is the addressed place, else zero for the or-tree
	assign tap   = (slot_x == cmd.pos) ? entry_q : '0;
	assign entry = entry_q;

endmodule

// ===== rtl/core/ordered_list_insert_delete_locate_unit.sv =====
`timescale 1ns / 1ps

// channel | dir | tdata (low bit up)                                    | tuser
// s_*     | in  | position[4:0], value[36:5], zero pad to 40           | kind[1:0]
// m_*     | out | ok[0], found_position[5:1], removed_value[37:6],
//         |     | count[42:38], zero pad to 48                          | -
//
// One word per clock while s_tready is high: all cells shift and compare in the same cycle, and the
// result sits in the output register in the cycle after the word is taken.
// s_tready stays high while the output register is empty or being drained.
// Reset clears the fill count and the output valid; cell contents past the
// fill count are never read, so they need no clearing.

module ordered_list_insert_delete_locate_unit import olidl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // position, value
	input  logic [KIND_W-1:0]      s_tuser,  // kind
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // ok, found_position, removed_value, count
);

	logic                   m_tvalid_q;
	logic [OUT_BITS-1:0]    res_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_nxt;

	logic                   accept;
	kind_t                  kind;
	logic [CMP_W-1:0]       pos_x;
	logic [CMP_W-1:0]       cnt_x;
	logic [WORD_W-1:0]      value;
	logic                   ins_ok;
	logic                   del_ok;
	cell_cmd_t              cmd;

	logic [WORD_W-1:0]      entries [CAPACITY];
	logic [WORD_W-1:0]      taps    [CAPACITY];
	logic [CAPACITY-1:0]    hits;

	logic [CMP_W-1:0]       first_hit;
	logic [WORD_W-1:0]      tap_or;
	logic                   res_ok;
	logic [CMP_W-1:0]       res_found;
	logic [WORD_W-1:0]      res_removed;

	// input word fields
	assign accept = s_tvalid && s_tready;
	assign kind   = kind_t'(s_tuser);
	assign pos_x  = CMP_W'(s_tdata[IN_POS_LSB +: POS_W]);
	assign value  = s_tdata[IN_VAL_LSB +: WORD_W];
	assign cnt_x  = CMP_W'(count_q);

	// bounds checks
	assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1)) &&
			(cnt_x < CMP_W'(CAPACITY));
	assign del_ok = (pos_x != '0) && (pos_x <= cnt_x);

	// broadcast to the chain
	always_comb begin
		cmd.op    = OP_HOLD;
		cmd.pos   = pos_x;
		cmd.count = cnt_x;
		cmd.value = value;
		count_nxt = count_q;
		if (accept) begin
			unique case (kind)
				KIND_INSERT: begin
					if (ins_ok) begin
						cmd.op    = OP_INSERT;
						count_nxt = count_q + CNT_W'(1);
					end
				end
				KIND_DELETE: begin
					if (del_ok) begin
						cmd.op    = OP_DELETE;
						count_nxt = count_q - CNT_W'(1);
					end
				end
				KIND_LOCATE: begin
					cmd.op = OP_HOLD;
				end
				default: begin
					cmd.op = OP_HOLD;
				end
			endcase
		end
	end

	// chain of cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entries[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entries[g+1];
		end

		olidl_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.slot        (CNT_W'(g + 1)),
			.left_entry  (left_w),
			.right_entry (right_w),
			.entry       (entries[g]),
			.hit         (hits[g]),
			.tap         (taps[g])
		);
	end

	// lowest matching place
	always_comb begin
		first_hit = '0;
		for (int k = CAPACITY - 1; k >= 0; k--) begin
			if (hits[k]) begin
				first_hit = CMP_W'(k + 1);
			end
		end
	end

	// addressed entry for delete
	always_comb begin
		tap_or = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			tap_or = tap_or | taps[k];
		end
	end

	// result fields
	always_comb begin
		res_ok      = 1'b0;
		res_found   = '0;
		res_removed = '0;
		unique case (kind)
			KIND_INSERT: begin
				res_ok = ins_ok;
			end
			KIND_DELETE: begin
				res_ok      = del_ok;
				res_removed = del_ok ? tap_or : '0;
			end
			KIND_LOCATE: begin
				res_ok    = |hits;
				res_found = first_hit;
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			count_q    <= '0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= {fit_pos(CMP_W'(count_nxt)), res_removed, fit_pos(res_found), res_ok};
		end
	end

	assign s_tready = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(res_q);

endmodule

// ===== rtl/core/olidl_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module olidl_checker import olidl_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,  // position, value
	input logic [KIND_W-1:0]      s_tuser,  // kind
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata   // ok, found_position, removed_value, count
);

	logic                ok_w;
	logic [POS_W-1:0]    found_w;
	logic [WORD_W-1:0]   removed_w;
	logic [POS_W-1:0]    count_w;
	logic                ins_zero_w;

	assign ok_w      = m_tdata[OK_BIT];
	assign found_w   = m_tdata[FOUND_LSB +: POS_W];
	assign removed_w = m_tdata[REMOVED_LSB +: WORD_W];
	assign count_w   = m_tdata[COUNT_LSB +: POS_W];

	// insert at place zero taken this cycle
	assign ins_zero_w = s_tvalid && s_tready && (s_tuser == KIND_INSERT) &&
			(s_tdata[IN_POS_LSB +: POS_W] == '0);

	// a stalled result word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

	// an empty output register always takes a word
	`ASSERT_IMPLIES(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready, "input stalled with output register empty")

	// a failed operation reports no place and no removed word
	`ASSERT_IMPLIES(a_fail_clean, clk, arst_n, m_tvalid && !ok_w, found_w == '0 && removed_w == '0, "failed operation carries data")

	// a reported place lies inside the list
	`ASSERT_IMPLIES(a_found_in_range, clk, arst_n, m_tvalid && found_w != '0, ok_w && found_w <= count_w, "found place outside the list")

	// an insert at place zero is answered next cycle as a failure
	`ASSERT_NEXT(a_ins_zero_fails, clk, arst_n, ins_zero_w, m_tvalid && !ok_w, "insert at place zero did not fail")

endmodule

bind ordered_list_insert_delete_locate_unit olidl_checker u_olidl_checker (.*);

// ===== tb/ordered_list_insert_delete_locate_unit_tb.sv =====
`timescale 1ns / 1ps

module ordered_list_insert_delete_locate_unit_tb;
	import olidl_pkg::*;

	localparam int RANDOM_WORDS = 900;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	// one result word, split into its fields
	typedef struct packed {
		logic              ok;
		logic [POS_W-1:0]  found;
		logic [WORD_W-1:0] removed;
		logic [POS_W-1:0]  count;
	} list_result_t;

	// one row of the directed table; typed rows carry their own expected word
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] val;
		logic              typed;
		list_result_t      want;
	} op_row_t;

	localparam list_result_t NO_RESULT = '0;

	localparam op_row_t OP_ROWS [16] = '{
		// empty list: locate misses, delete and bad inserts fail
		'{KIND_LOCATE, 5'd0,  32'h0000_0000, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd0}},
		'{KIND_DELETE, 5'd1,  32'h0000_0000, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd0}},
		'{KIND_INSERT, 5'd0,  32'h0000_0005, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd0}},
		'{KIND_INSERT, 5'd2,  32'h0000_0005, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd0}},
		// extreme words, appended then pushed to the front
		'{KIND_INSERT, 5'd1,  32'h8000_0000, 1'b1, '{1'b1, 5'd0, 32'h0, 5'd1}},
		'{KIND_INSERT, 5'd2,  32'h7fff_ffff, 1'b1, '{1'b1, 5'd0, 32'h0, 5'd2}},
		'{KIND_INSERT, 5'd1,  32'hffff_ffff, 1'b0, NO_RESULT},
		'{KIND_INSERT, 5'd31, 32'h0000_0000, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd3}},
		// unused kind leaves the list alone
		'{KIND_SPARE,  5'd5,  32'h1234_5678, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd3}},
		'{KIND_LOCATE, 5'd31, 32'h7fff_ffff, 1'b0, NO_RESULT},
		'{KIND_LOCATE, 5'd0,  32'h0000_0000, 1'b0, NO_RESULT},
		// delete outside the list
		'{KIND_DELETE, 5'd0,  32'h0000_0000, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd3}},
		'{KIND_DELETE, 5'd4,  32'h0000_0000, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd3}},
		'{KIND_DELETE, 5'd2,  32'h0000_0000, 1'b0, NO_RESULT},
		// duplicate word, locate gives the first
		'{KIND_INSERT, 5'd1,  32'hffff_ffff, 1'b0, NO_RESULT},
		'{KIND_LOCATE, 5'd0,  32'hffff_ffff, 1'b0, NO_RESULT}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [KIND_W-1:0]      s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// shadow of the list kept by the predictor
	logic [WORD_W-1:0] list_words [CAPACITY] = '{default: '0};
	int                list_len = 0;

	list_result_t pending_results [$];
	int           error_count = 0;
	int           burst_left = 0;
	int           cycle_count = 0;
	bit           hold_request = 1'b0;

	ordered_list_insert_delete_locate_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// apply one operation to the shadow list and return the result word
	function automatic list_result_t apply_list_op(input logic [KIND_W-1:0] kind,
			input logic [POS_W-1:0] pos, input logic [WORD_W-1:0] val);
		list_result_t res;
		int p;
		res = '0;
		p = int'(pos);
		if (kind == KIND_INSERT) begin
			if (p >= 1 && p <= list_len + 1 && list_len < CAPACITY) begin
				for (int k = list_len; k >= p; k--)
					list_words[k] = list_words[k-1];
				list_words[p-1] = val;
				list_len++;
				res.ok = 1'b1;
			end
		end else if (kind == KIND_DELETE) begin
			if (p >= 1 && p <= list_len) begin
				res.removed = list_words[p-1];
				for (int k = p; k < list_len; k++)
					list_words[k-1] = list_words[k];
				list_len--;
				res.ok = 1'b1;
			end
		end else if (kind == KIND_LOCATE) begin
			for (int k = 0; k < list_len; k++) begin
				if (list_words[k] == val && !res.ok) begin
					res.found = POS_W'(k + 1);
					res.ok = 1'b1;
				end
			end
		end
		res.count = POS_W'(list_len);
		return res;
	endfunction

	// a word already in the list, an extreme, or anything at all
	function automatic logic [WORD_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 3);
		if (sel == 0 && list_len > 0)
			return list_words[$urandom_range(0, list_len - 1)];
		if (sel == 1) begin
			case ($urandom_range(0, 4))
				0: return 32'h0000_0000;
				1: return 32'hffff_ffff;
				2: return 32'h8000_0000;
				3: return 32'h7fff_ffff;
				default: return WORD_W'($urandom_range(1, 4));
			endcase
		end
		return $urandom;
	endfunction

	// offer one word in bursts with random gaps, then log its expected result
	task automatic send_word(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
			input logic [WORD_W-1:0] val, input logic typed, input list_result_t want);
		logic [IN_TDATA_W-1:0] packed_in;
		list_result_t predicted;
		int gap;
		packed_in = '0;
		packed_in[IN_POS_LSB +: POS_W] = pos;
		packed_in[IN_VAL_LSB +: WORD_W] = val;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= packed_in;
		do @(posedge clk); while (!s_tready);
		predicted = apply_list_op(kind, pos, val);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// stimulus
	initial begin
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  pos;
		bit growing;
		int roll;
		growing = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OP_ROWS[i])
			send_word(OP_ROWS[i].kind, OP_ROWS[i].pos, OP_ROWS[i].val,
				OP_ROWS[i].typed, OP_ROWS[i].want);
		// fill up, then poke the full list
		while (list_len < CAPACITY)
			send_word(KIND_INSERT, POS_W'($urandom_range(1, list_len + 1)), pick_value(),
				1'b0, NO_RESULT);
		send_word(KIND_INSERT, 5'd1, 32'h5a5a_5a5a, 1'b1,
			'{1'b0, 5'd0, 32'h0, POS_W'(CAPACITY)});
		send_word(KIND_DELETE, POS_W'(CAPACITY + 1), 32'h0, 1'b1,
			'{1'b0, 5'd0, 32'h0, POS_W'(CAPACITY)});
		send_word(KIND_DELETE, POS_W'(CAPACITY), 32'h0, 1'b0, NO_RESULT);
		send_word(KIND_DELETE, 5'd1, 32'h0, 1'b0, NO_RESULT);

		// random part: growing and shrinking phases, mostly valid positions
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 48 == 0)
				growing = 1'($urandom_range(0, 1));
			if (n == 100 || n == 600)
				hold_request = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				kind = KIND_SPARE;
				pos = POS_W'($urandom);
			end else if (roll < 12) begin
				case ($urandom_range(0, 2))
					0: kind = KIND_INSERT;
					1: kind = KIND_DELETE;
					default: kind = KIND_LOCATE;
				endcase
				pos = POS_W'($urandom);
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < (growing ? 55 : 20)) begin
					kind = KIND_INSERT;
					pos = POS_W'($urandom_range(1, list_len + 1));
				end else if (roll < 75) begin
					kind = KIND_DELETE;
					pos = (list_len == 0) ? 5'd1 : POS_W'($urandom_range(1, list_len));
				end else begin
					kind = KIND_LOCATE;
					pos = POS_W'($urandom);
				end
			end
			send_word(kind, pos, pick_value(), 1'b0, NO_RESULT);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("ordered_list_insert_delete_locate_unit_tb OK");
		else
			$display("ordered_list_insert_delete_locate_unit_tb NOT OK");
		$finish;
	end

	// receiver: changing stall patterns, with a long hold-off on request
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(5, 60);
			end
			left--;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// compare each taken result word with the oldest expectation
	always @(posedge clk) begin : check_out
		list_result_t want;
		list_result_t seen;
		if (arst_n && m_tvalid && m_tready) begin
			seen.ok = m_tdata[OK_BIT];
			seen.found = m_tdata[FOUND_LSB +: POS_W];
			seen.removed = m_tdata[REMOVED_LSB +: WORD_W];
			seen.count = m_tdata[COUNT_LSB +: POS_W];
			if (pending_results.size() == 0) begin
				$display("%t unexpected result word %h", $time, m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (seen.ok !== want.ok) begin
					$display("%t ok: expected %h actual %h", $time, want.ok, seen.ok);
					error_count++;
				end
				if (seen.found !== want.found) begin
					$display("%t found_position: expected %0d actual %0d",
						$time, want.found, seen.found);
					error_count++;
				end
				if (seen.removed !== want.removed) begin
					$display("%t removed_value: expected %h actual %h",
						$time, want.removed, seen.removed);
					error_count++;
				end
				if (seen.count !== want.count) begin
					$display("%t count: expected %0d actual %0d", $time, want.count, seen.count);
					error_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%t timeout after %0d cycles", $time, cycle_count);
		$display("ordered_list_insert_delete_locate_unit_tb NOT OK");
		$finish;
	end

endmodule
